// ----- design/bssa_pkg.sv -----
// ----------------------------------------------------------------------------
// bssa_pkg
// Shared types, widths and codes for the bitmap slab slot allocator.
// ----------------------------------------------------------------------------
package bssa_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_BLOCKS_DEF   = 16;
  localparam int SLOTS_MAX_DEF    = 64;
  localparam int HEADER_BYTES_DEF = 32;

  // Fixed field widths.
  localparam int CHUNK_W    = 13;
  localparam int SPB_W      = 7;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int ADDR_W     = 32;
  localparam int NUM_W      = 10;
  localparam int COUNT_W    = 5;
  localparam int STATUS_W   = 2;

  // The slot number packs the slab index above a fixed six-bit slot field.
  localparam int NUM_SHIFT = 6;

  // Register reset values.
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 13'd16;
  localparam logic [SPB_W-1:0]   SPB_RESET   = 7'd64;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ALLOC     = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_FREED     = 2'd2,
    STATUS_OUTSIDE   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHUNK_SIZE      = 1'b0,
    REG_SLOTS_PER_BLOCK = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ASCAN,
    S_FSCAN,
    S_FDIV,
    S_FRD,
    S_FWR,
    S_MUL,
    S_SUM,
    S_OUT
  } state_t;

endpackage

// ----- design/bssa_req_if.sv -----
// ----------------------------------------------------------------------------
// bssa_req_if
// Request channel: one word carries a command and an address to free.
// ----------------------------------------------------------------------------
interface bssa_req_if;
  logic                         valid;
  logic                         ready;
  bssa_pkg::cmd_t               cmd;
  logic [bssa_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output cmd, output address, input ready);
  modport sink   (input valid, input cmd, input address, output ready);
endinterface

// ----- design/bssa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bssa_rsp_if
// Response channel: one word per request with status, slot and slab count.
// ----------------------------------------------------------------------------
interface bssa_rsp_if;
  logic                          valid;
  logic                          ready;
  bssa_pkg::status_t             status;
  logic [bssa_pkg::ADDR_W-1:0]   slot_address;
  logic [bssa_pkg::NUM_W-1:0]    slot_number;
  logic [bssa_pkg::COUNT_W-1:0]  active_count;

  modport source (output valid, output status, output slot_address,
                  output slot_number, output active_count, input ready);
  modport sink   (input valid, input status, input slot_address,
                  input slot_number, input active_count, output ready);
endinterface

// ----- design/bssa_ram.sv -----
// ----------------------------------------------------------------------------
// bssa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; the read data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/bitmap_slab_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_slab_slot_allocator
// First-fit slot allocator over a pool of slabs, one usage bitmap per slab.
// ----------------------------------------------------------------------------
// The block handles one request at a time; a response waits in an output
// register while the next request is taken. Allocate reads one slab bitmap
// per cycle through the memory read port until it finds a free slot or opens
// a new slab, then writes the bitmap, multiplies and sums the slot address;
// an exhausted pool answers straight after the scan. Free walks slab bases
// one per cycle to find the owning slab, then runs a one-bit-per-cycle divide
// by the chunk size, a read-modify-write of the bitmap and the address
// multiply; an address outside every active slab answers straight after the
// walk. The next request can be taken in the cycle after the response is
// loaded. No clearing pass is needed after reset; per-slab valid bits make
// unwritten bitmaps read as all free.
// Registers: index 0 is the chunk size in bytes, index 1 the slots per slab.
module bitmap_slab_slot_allocator #(
  parameter int MAX_BLOCKS   = bssa_pkg::MAX_BLOCKS_DEF,
  parameter int SLOTS_MAX    = bssa_pkg::SLOTS_MAX_DEF,
  parameter int HEADER_BYTES = bssa_pkg::HEADER_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [bssa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bssa_pkg::CFG_DATA_W-1:0]   cfg_data,
  bssa_req_if.sink                          req,
  bssa_rsp_if.source                        rsp
);

  localparam int ADDR_W    = bssa_pkg::ADDR_W;
  localparam int NUM_W     = bssa_pkg::NUM_W;
  localparam int COUNT_W   = bssa_pkg::COUNT_W;
  localparam int CHUNK_W   = bssa_pkg::CHUNK_W;
  localparam int SPB_W     = bssa_pkg::SPB_W;
  localparam int NUM_SHIFT = bssa_pkg::NUM_SHIFT;
  localparam int IDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int SIDX_W    = (SLOTS_MAX > 1) ? $clog2(SLOTS_MAX) : 1;
  localparam int EFF_W     = $clog2(SLOTS_MAX + 1);
  localparam int STRIDE_W  = $clog2(HEADER_BYTES + ((1 << CHUNK_W) - 1) * SLOTS_MAX + 1);
  localparam int DVS_W     = CHUNK_W + SIDX_W;
  localparam int REM_W     = (STRIDE_W > DVS_W) ? STRIDE_W : DVS_W;
  localparam int DCNT_W    = $clog2(SIDX_W + 1);
  localparam int PB_W      = IDX_W + STRIDE_W;
  localparam int PS_W      = SIDX_W + CHUNK_W;
  localparam int LIM_W     = ADDR_W + 1;

  // Control state.
  bssa_pkg::state_t       state, state_next;
  logic [CHUNK_W-1:0]     chunk_size;
  logic [SPB_W-1:0]       slots_per_block;
  logic [CNT_W-1:0]       active;
  logic [MAX_BLOCKS-1:0]  valid_bits;
  logic                   rd_vld;
  logic                   out_valid;

  // Datapath registers.
  bssa_pkg::cmd_t         cmd_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [CNT_W-1:0]       blk;
  logic [IDX_W-1:0]       chk_blk;
  logic [IDX_W-1:0]       hit_blk;
  logic [SIDX_W-1:0]      hit_slot;
  logic [SLOTS_MAX-1:0]   wr_word;
  logic [ADDR_W-1:0]      base;
  logic [REM_W-1:0]       rem;
  logic [REM_W-1:0]       dvs;
  logic [DCNT_W-1:0]      div_cnt;
  logic [STRIDE_W-1:0]    stride;
  logic [PB_W-1:0]        prod_b;
  logic [PS_W-1:0]        prod_s;
  bssa_pkg::status_t      res_status;
  logic [ADDR_W-1:0]      res_addr;
  logic [NUM_W-1:0]       res_num;
  bssa_pkg::status_t      out_status;
  logic [ADDR_W-1:0]      out_addr;
  logic [NUM_W-1:0]       out_num;
  logic [COUNT_W-1:0]     out_count;

  // Combinational helpers.
  logic [CHUNK_W-1:0]     eff_chunk;
  logic [EFF_W-1:0]       eff_slots;
  logic [SLOTS_MAX-1:0]   slot_mask;
  logic [SLOTS_MAX-1:0]   rd_word;
  logic [SLOTS_MAX-1:0]   free_bits;
  logic [SIDX_W-1:0]      first_free;
  logic                   acc;
  logic                   found;
  logic                   scan_more;
  logic                   can_grow;
  logic                   fs_hit;
  logic [STRIDE_W-1:0]    off;
  logic [REM_W-1:0]       rem_init;
  logic                   div_ge;
  logic                   out_free;

  // Memory port.
  logic                   ram_we;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic [SLOTS_MAX-1:0]   ram_rdata;

  // Effective configuration: zero chunk acts as one, slot count clamped.
  always_comb begin
    eff_chunk = (chunk_size == '0) ? CHUNK_W'(1) : chunk_size;
    if (slots_per_block == '0) begin
      eff_slots = EFF_W'(1);
    end else if (slots_per_block > SPB_W'(SLOTS_MAX)) begin
      eff_slots = EFF_W'(SLOTS_MAX);
    end else begin
      eff_slots = EFF_W'(slots_per_block);
    end
    for (int i = 0; i < SLOTS_MAX; i++) begin
      slot_mask[i] = (i < int'(eff_slots));
    end
  end

  // Bitmap of the slab last read; a slab never written reads as all free.
  always_comb begin
    rd_word   = valid_bits[chk_blk] ? ram_rdata : '0;
    free_bits = ~rd_word & slot_mask;
    first_free = '0;
    for (int i = SLOTS_MAX - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        first_free = SIDX_W'(i);
      end
    end
  end

  // Decisions shared by the state machine and the datapath.
  always_comb begin
    acc       = req.valid && req.ready;
    found     = rd_vld && (|free_bits);
    scan_more = (blk < active);
    can_grow  = (active < CNT_W'(MAX_BLOCKS));
    fs_hit    = ({1'b0, addr_q} < ({1'b0, base} + LIM_W'(stride)));
    off       = STRIDE_W'(addr_q - base);
    rem_init  = (off > STRIDE_W'(HEADER_BYTES)) ?
                REM_W'(off - STRIDE_W'(HEADER_BYTES)) : '0;
    div_ge    = (rem >= dvs);
    out_free  = !out_valid || rsp.ready;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bssa_pkg::S_IDLE: begin
        if (acc) begin
          state_next = (req.cmd == bssa_pkg::CMD_FREE) ? bssa_pkg::S_FSCAN
                                                       : bssa_pkg::S_ASCAN;
        end
      end
      bssa_pkg::S_ASCAN: begin
        if (found) begin
          state_next = bssa_pkg::S_MUL;
        end else if (!scan_more) begin
          state_next = can_grow ? bssa_pkg::S_MUL : bssa_pkg::S_OUT;
        end
      end
      bssa_pkg::S_FSCAN: begin
        if (!scan_more) begin
          state_next = bssa_pkg::S_OUT;
        end else if (fs_hit) begin
          state_next = bssa_pkg::S_FDIV;
        end
      end
      bssa_pkg::S_FDIV: begin
        if (div_cnt == '0) begin
          state_next = bssa_pkg::S_FRD;
        end
      end
      bssa_pkg::S_FRD: state_next = bssa_pkg::S_FWR;
      bssa_pkg::S_FWR: state_next = bssa_pkg::S_MUL;
      bssa_pkg::S_MUL: state_next = bssa_pkg::S_SUM;
      bssa_pkg::S_SUM: state_next = bssa_pkg::S_OUT;
      bssa_pkg::S_OUT: begin
        if (out_free) begin
          state_next = bssa_pkg::S_IDLE;
        end
      end
      default: state_next = bssa_pkg::S_IDLE;
    endcase
  end

  // Memory control: reads during the allocate scan and before a free, one write
  // per successful allocate or free in the multiply step.
  always_comb begin
    ram_re    = ((state == bssa_pkg::S_ASCAN) && !found && scan_more) ||
                (state == bssa_pkg::S_FRD);
    ram_raddr = (state == bssa_pkg::S_FRD) ? hit_blk : IDX_W'(blk);
    ram_we    = (state == bssa_pkg::S_MUL);
  end

  bssa_ram #(
    .WIDTH (SLOTS_MAX),
    .DEPTH (MAX_BLOCKS)
  ) u_usage_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hit_blk),
    .wdata (wr_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control registers, configuration and slab bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= bssa_pkg::S_IDLE;
      chunk_size      <= bssa_pkg::CHUNK_RESET;
      slots_per_block <= bssa_pkg::SPB_RESET;
      active          <= CNT_W'(1);
      valid_bits      <= '0;
      rd_vld          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= ram_re && (state == bssa_pkg::S_ASCAN);
      if (cfg_wr_en) begin
        case (bssa_pkg::cfg_reg_t'(cfg_index))
          bssa_pkg::REG_CHUNK_SIZE:      chunk_size      <= CHUNK_W'(cfg_data);
          bssa_pkg::REG_SLOTS_PER_BLOCK: slots_per_block <= SPB_W'(cfg_data);
          default: ;
        endcase
      end
      // A new slab is opened when every active slab is full and the pool has room.
      if ((state == bssa_pkg::S_ASCAN) && !found && !scan_more && can_grow) begin
        active <= active + CNT_W'(1);
      end
      if (ram_we) begin
        valid_bits[hit_blk] <= 1'b1;
      end
      if ((state == bssa_pkg::S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Slab stride follows the configuration in the next cycle.
  always_ff @(posedge clk) begin
    stride <= STRIDE_W'(HEADER_BYTES) + STRIDE_W'(eff_chunk) * STRIDE_W'(eff_slots);
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      bssa_pkg::S_IDLE: begin
        if (acc) begin
          cmd_q  <= req.cmd;
          addr_q <= req.address;
          blk    <= '0;
          base   <= '0;
        end
      end
      bssa_pkg::S_ASCAN: begin
        if (found) begin
          hit_blk  <= chk_blk;
          hit_slot <= first_free;
          wr_word  <= rd_word | (SLOTS_MAX'(1) << first_free);
        end else if (scan_more) begin
          chk_blk <= IDX_W'(blk);
          blk     <= blk + CNT_W'(1);
        end else begin
          // All active slabs full: slot 0 of the next slab, or exhausted.
          hit_blk    <= IDX_W'(active);
          hit_slot   <= '0;
          wr_word    <= SLOTS_MAX'(1);
          res_status <= bssa_pkg::STATUS_EXHAUSTED;
          res_addr   <= '0;
          res_num    <= '0;
        end
      end
      bssa_pkg::S_FSCAN: begin
        if (!scan_more) begin
          res_status <= bssa_pkg::STATUS_OUTSIDE;
          res_addr   <= addr_q;
          res_num    <= '0;
        end else if (fs_hit) begin
          hit_blk  <= IDX_W'(blk);
          hit_slot <= '0;
          rem      <= rem_init;
          dvs      <= REM_W'(eff_chunk) << (SIDX_W - 1);
          div_cnt  <= DCNT_W'(SIDX_W - 1);
        end else begin
          base <= base + ADDR_W'(stride);
          blk  <= blk + CNT_W'(1);
        end
      end
      bssa_pkg::S_FDIV: begin
        // Restoring division, one quotient bit per cycle.
        if (div_ge) begin
          rem <= rem - dvs;
        end
        hit_slot <= SIDX_W'({hit_slot, div_ge});
        dvs      <= dvs >> 1;
        div_cnt  <= div_cnt - DCNT_W'(1);
      end
      bssa_pkg::S_FRD: begin
        chk_blk <= hit_blk;
      end
      bssa_pkg::S_FWR: begin
        wr_word <= rd_word & ~(SLOTS_MAX'(1) << hit_slot);
      end
      bssa_pkg::S_MUL: begin
        prod_b <= PB_W'(hit_blk) * PB_W'(stride);
        prod_s <= PS_W'(hit_slot) * PS_W'(eff_chunk);
      end
      bssa_pkg::S_SUM: begin
        res_status <= (cmd_q == bssa_pkg::CMD_FREE) ? bssa_pkg::STATUS_FREED
                                                    : bssa_pkg::STATUS_ALLOC;
        res_addr   <= ADDR_W'(prod_b) + ADDR_W'(HEADER_BYTES) + ADDR_W'(prod_s);
        res_num    <= NUM_W'({hit_blk, NUM_SHIFT'(hit_slot)});
      end
      bssa_pkg::S_OUT: begin
        if (out_free) begin
          out_status <= res_status;
          out_addr   <= res_addr;
          out_num    <= res_num;
          out_count  <= COUNT_W'(active);
        end
      end
      default: ;
    endcase
  end

  // Ports.
  assign req.ready        = (state == bssa_pkg::S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.slot_address = out_addr;
  assign rsp.slot_number  = out_num;
  assign rsp.active_count = out_count;

endmodule

// ----- design/bssa_checker.sv -----
// ----------------------------------------------------------------------------
// bssa_checker
// Port-level checks for the slab allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bssa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [bssa_pkg::STATUS_W-1:0]   rsp_status,
  input logic [bssa_pkg::ADDR_W-1:0]     rsp_slot_address,
  input logic [bssa_pkg::NUM_W-1:0]      rsp_slot_number,
  input logic [bssa_pkg::COUNT_W-1:0]    rsp_active_count
);

  // A stalled response word keeps its valid and its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_slot_address) && $stable(rsp_slot_number) &&
      $stable(rsp_active_count))
    else $error("response word changed while stalled");

  // Only one request is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  // No response can appear in the cycle right after a request is taken.
  a_no_instant_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("response appeared without any work cycles");

endmodule

bind bitmap_slab_slot_allocator bssa_checker u_bssa_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_slot_address (rsp.slot_address),
  .rsp_slot_number  (rsp.slot_number),
  .rsp_active_count (rsp.active_count)
);
